[hdl/gcp_pkg.sv]
// Shared constants, opcodes and types of the color phase controller.
package gcp_pkg;

  localparam int WORD_BITS = 64;
  localparam int HALF_BITS = 32;
  localparam int LANES = 32;
  localparam int HISTORY_DEPTH = 4;

  localparam logic [WORD_BITS-1:0] GREY_MASK =
    (64'd1 << LANES) - 64'd1;
  localparam logic [WORD_BITS-1:0] BLACK_MASK = GREY_MASK << HALF_BITS;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    OP_MERGE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_SWEEP   = 2'd2,
    OP_TRACE   = 2'd3
  } op_t;

  typedef struct packed {
    word_t trace_mask;
    word_t delete_mask;
    word_t clear_mask;
  } masks_t;

endpackage

[hdl/gcp_phase_unit.sv]
// Phase state: masks, allocation color, color and shade histories.
module gcp_phase_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  gcp_pkg::op_t   opcode,
  input  gcp_pkg::word_t shade_bits,
  output gcp_pkg::masks_t masks,
  output gcp_pkg::word_t alloc_next
);
  import gcp_pkg::*;

  word_t color_history [HISTORY_DEPTH];
  word_t shade_history [HISTORY_DEPTH];
  word_t alloc_color;
  word_t in_use_mask;
  word_t trace_mask;
  word_t delete_mask;
  word_t clear_mask;

  word_t fresh;
  word_t alloc_fresh;
  word_t trace_fresh;
  word_t stable;
  word_t alloc_kept;
  word_t in_use_kept;
  logic [LANES-1:0] free_low;
  logic [LANES-1:0] free_inc;
  word_t grey;
  word_t in_use_next;
  word_t trace_next;
  word_t clear_next;

  always_comb begin
    fresh       = color_history[0] & ~color_history[1];
    alloc_fresh = alloc_color | (fresh << HALF_BITS);
    trace_fresh = trace_mask | (fresh >> HALF_BITS);
    stable      = trace_fresh & ~shade_history[0] & ~shade_history[1]
                  & ~shade_history[2];
    trace_next  = trace_fresh & ~stable;
    alloc_kept  = alloc_fresh & ~(delete_mask | (delete_mask << HALF_BITS));
    clear_next  = ~color_history[1] & color_history[2];
    in_use_kept = in_use_mask & ~clear_mask;
    free_low    = in_use_kept[LANES-1:0];
    free_inc    = free_low + {{(LANES-1){1'b0}}, 1'b1};
    grey        = {{(WORD_BITS-LANES){1'b0}}, free_inc & ~free_low};
    in_use_next = in_use_kept | grey | (grey << HALF_BITS);
    if (opcode == OP_ADVANCE) begin
      alloc_next = alloc_kept | grey;
    end else begin
      alloc_next = alloc_color;
    end
  end

  assign masks.trace_mask  = trace_mask;
  assign masks.delete_mask = delete_mask;
  assign masks.clear_mask  = clear_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        color_history[i] <= '0;
        shade_history[i] <= '0;
      end
      alloc_color <= '0;
      in_use_mask <= '0;
      trace_mask  <= '0;
      delete_mask <= '0;
      clear_mask  <= '0;
    end else if (en) begin
      case (opcode)
        OP_MERGE: begin
          shade_history[0] <= shade_history[0] | shade_bits;
        end
        OP_ADVANCE: begin
          alloc_color <= alloc_next;
          in_use_mask <= in_use_next;
          trace_mask  <= trace_next;
          delete_mask <= stable;
          clear_mask  <= clear_next;
          for (int i = 1; i < HISTORY_DEPTH; i++) begin
            color_history[i] <= color_history[i-1];
            shade_history[i] <= shade_history[i-1];
          end
          color_history[0] <= alloc_next;
          shade_history[0] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/gcp_object_unit.sv]
// Sweep classification and child tracing of one object color word.
module gcp_object_unit (
  input  gcp_pkg::op_t    opcode,
  input  gcp_pkg::word_t  object_color,
  input  gcp_pkg::word_t  parent_word,
  input  gcp_pkg::masks_t masks,
  output gcp_pkg::word_t  new_color,
  output logic            push_grey,
  output logic            survives,
  output logic            violation
);
  import gcp_pkg::*;

  word_t sweep_color;
  word_t traced;
  word_t trace_color;
  logic  black_added;
  logic  balanced;

  always_comb begin
    sweep_color = (object_color | ((object_color & masks.trace_mask) << HALF_BITS))
                  & ~masks.clear_mask;
    black_added = |(~object_color & sweep_color & BLACK_MASK);
    balanced    = (((object_color >> HALF_BITS) & masks.delete_mask) ==
                   (object_color & masks.delete_mask));
    traced      = object_color | (parent_word & masks.trace_mask);
    trace_color = (traced | ((traced & masks.trace_mask) << HALF_BITS))
                  & ~masks.clear_mask;

    new_color = '0;
    push_grey = 1'b0;
    survives  = 1'b0;
    violation = 1'b0;
    case (opcode)
      OP_SWEEP: begin
        new_color = sweep_color;
        push_grey = black_added;
        if ((masks.delete_mask == '0) || ((object_color & masks.delete_mask) != '0)) begin
          survives  = 1'b1;
          violation = ~balanced;
        end else begin
          violation = black_added;
        end
      end
      OP_TRACE: begin
        new_color = trace_color;
        push_grey = |(~object_color & trace_color);
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/gc_color_phase_controller.sv]
// Top level of the color phase controller: input beat register, units, result register.
// A beat passes through the input register and then the result register.
// Throughput: one beat per cycle while the result is not stalled; the phase state updates
// as a beat leaves the input register, so the next beat sees the updated state.
// A stalled result holds the input register; one further beat waits there.
// Reset (rst, synchronous): histories, masks and allocation color clear to zero.
module gc_color_phase_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     opcode,
  input  gcp_pkg::word_t shade_bits,
  input  gcp_pkg::word_t object_color,
  input  gcp_pkg::word_t parent_word,
  output logic           out_valid,
  input  logic           out_ready,
  output gcp_pkg::word_t published_color,
  output gcp_pkg::word_t new_color,
  output logic           push_grey,
  output logic           survives,
  output logic           violation
);
  import gcp_pkg::*;

  logic   item_valid;
  op_t    item_op;
  word_t  item_shade;
  word_t  item_object;
  word_t  item_parent;
  logic   advance;
  masks_t masks;
  word_t  alloc_next;
  word_t  obj_color;
  logic   obj_push;
  logic   obj_survives;
  logic   obj_violation;

  assign advance  = item_valid & (~out_valid | out_ready);
  assign in_ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_op     <= op_t'(opcode);
      item_shade  <= shade_bits;
      item_object <= object_color;
      item_parent <= parent_word;
    end
  end

  gcp_phase_unit u_phase (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .opcode     (item_op),
    .shade_bits (item_shade),
    .masks      (masks),
    .alloc_next (alloc_next)
  );

  gcp_object_unit u_object (
    .opcode       (item_op),
    .object_color (item_object),
    .parent_word  (item_parent),
    .masks        (masks),
    .new_color    (obj_color),
    .push_grey    (obj_push),
    .survives     (obj_survives),
    .violation    (obj_violation)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      published_color <= alloc_next;
      new_color       <= obj_color;
      push_grey       <= obj_push;
      survives        <= obj_survives;
      violation       <= obj_violation;
    end
  end

endmodule
